>>> rtl/core/priority_ready_queue_unit_assert.svh
// Assertion macros shared by the checkers of the priority ready queue.
// Needs no other file; each macro expands to one labeled concurrent assertion.
`ifndef PRIORITY_READY_QUEUE_UNIT_ASSERT_SVH
`define PRIORITY_READY_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRQ_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("priority ready queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define PRQ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("priority ready queue check failed");

// The consequent must hold in the cycle after reset is sampled low.
`define PRQ_ASSERT_AFTER_RESET(lbl, ck, rn, cons) \
  lbl: assert property (@(posedge ck) !rn |=> (cons)) \
    else $error("priority ready queue reset check failed");

`endif

>>> rtl/core/prq_pkg.sv
// Shared sizes, types and helpers of the priority ready queue.
// Used by every module of the block but prq_ram; depends on nothing.
`timescale 1ns / 1ps

package prq_pkg;

  localparam int NUM_PRIO    = 32;
  localparam int NUM_THREADS = 64;

  localparam int FUNC_W  = 2;
  localparam int TID_FW  = 6;
  localparam int PRIO_FW = 5;

  localparam int TID_W = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int LVL_W = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1;

  localparam int FLS_GROUPS = (NUM_PRIO + 7) / 8;
  localparam int FLS_GW     = (FLS_GROUPS > 1) ? $clog2(FLS_GROUPS) : 1;

  typedef logic [TID_W-1:0]    tid_t;
  typedef logic [LVL_W-1:0]    lvl_t;
  typedef logic [NUM_PRIO-1:0] map_t;

  typedef enum logic [FUNC_W-1:0] {
    OP_ADD_HEAD,
    OP_ADD_TAIL,
    OP_REMOVE
  } op_t;

  typedef struct packed {
    lvl_t prio;
    logic head_we;
    tid_t head_d;
    logic tail_we;
    tid_t tail_d;
  } list_wr_t;

  function automatic tid_t to_tid(logic [TID_FW-1:0] v);
    return tid_t'(v);
  endfunction

  function automatic lvl_t to_lvl(logic [PRIO_FW-1:0] v);
    return lvl_t'(v);
  endfunction

endpackage

>>> rtl/core/priority_ready_queue_unit.sv
// Priority ready queue: per-level thread lists, level bitmap and cached top level.
// A request is held in the request register, then its result in the result register; one request
// per cycle is sustained while results are taken.
// Synchronous reset clears the bitmap, the top level and all valid flags; the list
// and link tables are not cleared and need no clearing pass.
// Depends on prq_pkg, prq_ram, prq_fls and prq_list_table.
`timescale 1ns / 1ps

module priority_ready_queue_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [prq_pkg::FUNC_W-1:0]  in_func,
  input  logic [prq_pkg::TID_FW-1:0]  in_thread_id,
  input  logic [prq_pkg::PRIO_FW-1:0] in_prio,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_ready_valid,
  output logic [prq_pkg::PRIO_FW-1:0] out_top_prio,
  output logic [prq_pkg::TID_FW-1:0]  out_chosen_thread
);
  import prq_pkg::*;

  logic in_fire;
  logic s1_fire;

  logic                s1_valid_r;
  logic [FUNC_W-1:0]   s1_func_r;
  logic [TID_FW-1:0]   s1_tid_raw_r;
  logic [PRIO_FW-1:0]  s1_prio_raw_r;

  logic                out_valid_r;
  logic                out_rv_r;
  logic [PRIO_FW-1:0]  out_prio_r;
  logic [TID_FW-1:0]   out_tid_r;

  map_t bitmap_r, bitmap_nxt;
  logic top_valid_r, top_valid_nxt;
  lvl_t top_level_r, top_level_nxt;

  logic lw_next_vld_r;
  tid_t lw_next_addr_r, lw_next_data_r;
  logic lw_prev_vld_r;
  tid_t lw_prev_addr_r, lw_prev_data_r;

  tid_t     t;
  lvl_t     p;
  logic     s1_ok;
  logic     bit_p;
  map_t     onehot_p;
  map_t     clr_map;
  logic     fls_any;
  lvl_t     fls_idx;
  tid_t     next_rdata, prev_rdata;
  tid_t     next_t, prev_t;
  tid_t     head_p, tail_p, head_top;
  logic     is_head, is_tail;
  list_wr_t lt_wr;
  logic     next_we, prev_we;
  tid_t     next_waddr, next_wdata, prev_waddr, prev_wdata;
  tid_t     chosen;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  prq_ram #(.WIDTH(TID_W), .DEPTH(NUM_THREADS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (in_fire),
    .raddr (to_tid(in_thread_id)),
    .rdata (next_rdata)
  );

  prq_ram #(.WIDTH(TID_W), .DEPTH(NUM_THREADS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (in_fire),
    .raddr (to_tid(in_thread_id)),
    .rdata (prev_rdata)
  );

  prq_list_table u_list_table (
    .clk          (clk),
    .wr           (lt_wr),
    .rd_prio      (p),
    .rd_top       (top_level_nxt),
    .head_at_prio (head_p),
    .tail_at_prio (tail_p),
    .head_at_top  (head_top)
  );

  prq_fls u_fls (
    .bits (clr_map),
    .any  (fls_any),
    .idx  (fls_idx)
  );

  assign t        = to_tid(s1_tid_raw_r);
  assign p        = to_lvl(s1_prio_raw_r);
  assign s1_ok    = (int'(s1_tid_raw_r) < NUM_THREADS) && (int'(s1_prio_raw_r) < NUM_PRIO);
  assign onehot_p = map_t'(1) << p;
  assign bit_p    = s1_ok && ((bitmap_r & onehot_p) != '0);
  assign clr_map  = bitmap_r & ~onehot_p;
  assign is_head  = (head_p == t);
  assign is_tail  = (tail_p == t);

  // A link written by the previous request is not yet visible in the RAM read data.
  assign next_t = (lw_next_vld_r && lw_next_addr_r == t) ? lw_next_data_r : next_rdata;
  assign prev_t = (lw_prev_vld_r && lw_prev_addr_r == t) ? lw_prev_data_r : prev_rdata;

  always_comb begin
    bitmap_nxt    = bitmap_r;
    top_valid_nxt = top_valid_r;
    top_level_nxt = top_level_r;
    lt_wr         = '0;
    lt_wr.prio    = p;
    lt_wr.head_d  = t;
    lt_wr.tail_d  = t;
    next_we       = 1'b0;
    next_waddr    = t;
    next_wdata    = t;
    prev_we       = 1'b0;
    prev_waddr    = t;
    prev_wdata    = t;

    if (s1_ok) begin
      unique case (s1_func_r) inside
        OP_ADD_HEAD, OP_ADD_TAIL: begin
          if (!bit_p) begin
            lt_wr.head_we = 1'b1;
            lt_wr.tail_we = 1'b1;
            bitmap_nxt    = bitmap_r | onehot_p;
            if (!top_valid_r || top_level_r < p) begin
              top_level_nxt = p;
              top_valid_nxt = 1'b1;
            end
          end else if (s1_func_r == OP_ADD_TAIL) begin
            next_we       = 1'b1;
            next_waddr    = tail_p;
            prev_we       = 1'b1;
            prev_wdata    = tail_p;
            lt_wr.tail_we = 1'b1;
          end else begin
            prev_we       = 1'b1;
            prev_waddr    = head_p;
            next_we       = 1'b1;
            next_wdata    = head_p;
            lt_wr.head_we = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (bit_p) begin
            if (is_head && is_tail) begin
              bitmap_nxt    = clr_map;
              top_valid_nxt = fls_any;
              top_level_nxt = fls_any ? fls_idx : '0;
            end else if (is_head) begin
              lt_wr.head_we = 1'b1;
              lt_wr.head_d  = next_t;
            end else if (is_tail) begin
              lt_wr.tail_we = 1'b1;
              lt_wr.tail_d  = prev_t;
            end else begin
              next_we    = 1'b1;
              next_waddr = prev_t;
              next_wdata = next_t;
              prev_we    = 1'b1;
              prev_waddr = next_t;
              prev_wdata = prev_t;
            end
          end
        end
        default: begin
        end
      endcase
    end

    lt_wr.head_we = lt_wr.head_we && s1_fire;
    lt_wr.tail_we = lt_wr.tail_we && s1_fire;
    next_we       = next_we && s1_fire;
    prev_we       = prev_we && s1_fire;
  end

  assign chosen = (lt_wr.head_we && p == top_level_nxt) ? lt_wr.head_d : head_top;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      bitmap_r      <= '0;
      top_valid_r   <= 1'b0;
      top_level_r   <= '0;
      lw_next_vld_r <= 1'b0;
      lw_prev_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        bitmap_r    <= bitmap_nxt;
        top_valid_r <= top_valid_nxt;
        top_level_r <= top_level_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (next_we) begin
        lw_next_vld_r <= 1'b1;
      end
      if (prev_we) begin
        lw_prev_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r     <= in_func;
      s1_tid_raw_r  <= in_thread_id;
      s1_prio_raw_r <= in_prio;
    end
    if (s1_fire) begin
      out_rv_r   <= top_valid_nxt;
      out_prio_r <= top_valid_nxt ? PRIO_FW'(top_level_nxt) : '0;
      out_tid_r  <= top_valid_nxt ? TID_FW'(chosen) : '0;
    end
    if (next_we) begin
      lw_next_addr_r <= next_waddr;
      lw_next_data_r <= next_wdata;
    end
    if (prev_we) begin
      lw_prev_addr_r <= prev_waddr;
      lw_prev_data_r <= prev_wdata;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ready_valid   = out_rv_r;
  assign out_top_prio      = out_prio_r;
  assign out_chosen_thread = out_tid_r;

endmodule

>>> rtl/core/prq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read-before-write on an address collision; depends on nothing.
`timescale 1ns / 1ps

module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/prq_fls.sv
// Find-last-set over the level bitmap, in groups of eight bits.
// Depends on prq_pkg.
`timescale 1ns / 1ps

module prq_fls (
  input  prq_pkg::map_t bits,
  output logic          any,
  output prq_pkg::lvl_t idx
);
  import prq_pkg::*;

  logic [FLS_GROUPS*8-1:0] padded;
  logic [FLS_GROUPS-1:0]   grp_any;
  logic [FLS_GW-1:0]       sel_g;
  logic [7:0]              grp_bits;
  logic [2:0]              sel_b;

  always_comb begin
    padded = (FLS_GROUPS*8)'(bits);
    for (int g = 0; g < FLS_GROUPS; g++) begin
      grp_any[g] = |padded[g*8 +: 8];
    end
    sel_g = '0;
    for (int g = 0; g < FLS_GROUPS; g++) begin
      if (grp_any[g]) begin
        sel_g = FLS_GW'(g);
      end
    end
    grp_bits = padded[sel_g*8 +: 8];
    sel_b = '0;
    for (int b = 0; b < 8; b++) begin
      if (grp_bits[b]) begin
        sel_b = 3'(b);
      end
    end
    any = |bits;
    idx = LVL_W'({sel_g, sel_b});
  end

endmodule

>>> rtl/core/prq_list_table.sv
// Head and tail entry of every level's list, held in flip-flops.
// The head is kept twice so that each copy has a single read port. Depends on prq_pkg.
`timescale 1ns / 1ps

module prq_list_table (
  input  logic              clk,
  input  prq_pkg::list_wr_t wr,
  input  prq_pkg::lvl_t     rd_prio,
  input  prq_pkg::lvl_t     rd_top,
  output prq_pkg::tid_t     head_at_prio,
  output prq_pkg::tid_t     tail_at_prio,
  output prq_pkg::tid_t     head_at_top
);
  import prq_pkg::*;

  tid_t head_a_r [NUM_PRIO];
  tid_t head_b_r [NUM_PRIO];
  tid_t tail_r   [NUM_PRIO];

  always_ff @(posedge clk) begin
    if (wr.head_we) begin
      head_a_r[wr.prio] <= wr.head_d;
      head_b_r[wr.prio] <= wr.head_d;
    end
    if (wr.tail_we) begin
      tail_r[wr.prio] <= wr.tail_d;
    end
  end

  assign head_at_prio = head_a_r[rd_prio];
  assign tail_at_prio = tail_r[rd_prio];
  assign head_at_top  = head_b_r[rd_top];

endmodule

>>> rtl/core/prq_checker.sv
// Port-level checks of the priority ready queue and the bind that attaches them.
// Depends on prq_pkg and priority_ready_queue_unit_assert.svh.
`timescale 1ns / 1ps
`include "priority_ready_queue_unit_assert.svh"

module prq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [prq_pkg::FUNC_W-1:0]  in_func,
  input logic [prq_pkg::TID_FW-1:0]  in_thread_id,
  input logic [prq_pkg::PRIO_FW-1:0] in_prio,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_ready_valid,
  input logic [prq_pkg::PRIO_FW-1:0] out_top_prio,
  input logic [prq_pkg::TID_FW-1:0]  out_chosen_thread
);

  `PRQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_ready_valid) && $stable(out_top_prio) && $stable(out_chosen_thread))
  `PRQ_ASSERT_SAME(a_empty_zero, clk, rst_n, out_valid && !out_ready_valid, out_top_prio == 0 && out_chosen_thread == 0)
  `PRQ_ASSERT_AFTER_RESET(a_reset_no_result, clk, rst_n, !out_valid)
  `PRQ_ASSERT_AFTER_RESET(a_reset_ready, clk, rst_n, in_ready)

endmodule

bind priority_ready_queue_unit prq_checker u_prq_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for priority_ready_queue_unit, the per-level thread ready queue.
// A directed table and random request streams are checked against a predictor kept here.
// Depends on prq_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;
  import prq_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int WELL_FORMED_ITEMS = 1250;
  localparam int BROKEN_ITEMS = 130;
  localparam int DRAIN_EVERY = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_WAIT = 13;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic               rdy;
    logic [PRIO_FW-1:0] top;
    logic [TID_FW-1:0]  thr;
  } ready_view_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [TID_FW-1:0]  tid;
    logic [PRIO_FW-1:0] prio;
    logic               typed;
    ready_view_t        view;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [22] = '{
    '{FUNC_UNUSED, 6'd0,  5'd0,  1'b1, '{1'b0, 5'd0,  6'd0}},
    '{OP_REMOVE,   6'd5,  5'd7,  1'b1, '{1'b0, 5'd0,  6'd0}},
    '{OP_ADD_HEAD, 6'd0,  5'd0,  1'b1, '{1'b1, 5'd0,  6'd0}},
    '{OP_ADD_TAIL, 6'd63, 5'd31, 1'b1, '{1'b1, 5'd31, 6'd63}},
    '{OP_ADD_TAIL, 6'd1,  5'd31, 1'b0, '{1'b0, 5'd0,  6'd0}},
    '{OP_ADD_HEAD, 6'd2,  5'd31, 1'b0, '{1'b0, 5'd0,  6'd0}},
    '{OP_ADD_TAIL, 6'd3,  5'd31, 1'b0, '{1'b0, 5'd0,  6'd0}},
    '{OP_REMOVE,   6'd1,  5'd31, 1'b0, '{1'b0, 5'd0,  6'd0}},
    '{OP_REMOVE,   6'd2,  5'd31, 1'b0, '{1'b0, 5'd0,  6'd0}},
    '{OP_REMOVE,   6'd3,  5'd31, 1'b0, '{1'b0, 5'd0,  6'd0}},
    '{FUNC_UNUSED, 6'd63, 5'd31, 1'b0, '{1'b0, 5'd0,  6'd0}},
    '{OP_REMOVE,   6'd63, 5'd31, 1'b0, '{1'b0, 5'd0,  6'd0}},
    '{OP_ADD_TAIL, 6'd42, 5'd16, 1'b1, '{1'b1, 5'd16, 6'd42}},
    '{OP_ADD_HEAD, 6'd21, 5'd15, 1'b0, '{1'b0, 5'd0,  6'd0}},
    '{OP_REMOVE,   6'd42, 5'd16, 1'b0, '{1'b0, 5'd0,  6'd0}},
    '{OP_REMOVE,   6'd9,  5'd31, 1'b0, '{1'b0, 5'd0,  6'd0}},
    '{OP_REMOVE,   6'd21, 5'd15, 1'b0, '{1'b0, 5'd0,  6'd0}},
    '{OP_ADD_HEAD, 6'd63, 5'd0,  1'b0, '{1'b0, 5'd0,  6'd0}},
    '{OP_ADD_HEAD, 6'd62, 5'd0,  1'b0, '{1'b0, 5'd0,  6'd0}},
    '{OP_REMOVE,   6'd0,  5'd0,  1'b0, '{1'b0, 5'd0,  6'd0}},
    '{OP_REMOVE,   6'd63, 5'd0,  1'b0, '{1'b0, 5'd0,  6'd0}},
    '{OP_REMOVE,   6'd62, 5'd0,  1'b1, '{1'b0, 5'd0,  6'd0}}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [FUNC_W-1:0]  in_func;
  logic [TID_FW-1:0]  in_thread_id;
  logic [PRIO_FW-1:0] in_prio;
  logic               out_valid;
  logic               out_ready;
  logic               out_ready_valid;
  logic [PRIO_FW-1:0] out_top_prio;
  logic [TID_FW-1:0]  out_chosen_thread;

  map_t lvl_map;
  logic top_ok;
  lvl_t top_lvl;
  tid_t head_of [NUM_PRIO];
  tid_t tail_of [NUM_PRIO];
  tid_t next_of [NUM_THREADS];
  tid_t prev_of [NUM_THREADS];
  bit   next_set [NUM_THREADS];
  bit   prev_set [NUM_THREADS];

  int   lvl_of [NUM_THREADS];
  bit   filling;
  lvl_t hot_lvl [3];
  bit   tx_steady;
  bit   rx_steady;

  ready_view_t pending_views [$];
  int mismatches = 0;
  int stall_cycles = 0;

  priority_ready_queue_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_thread_id     (in_thread_id),
    .in_prio          (in_prio),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ready_valid  (out_ready_valid),
    .out_top_prio     (out_top_prio),
    .out_chosen_thread(out_chosen_thread)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ready_view_t apply_request(logic [FUNC_W-1:0] func, tid_t t, lvl_t p);
    ready_view_t v;
    tid_t old;
    tid_t bef;
    tid_t aft;
    logic at_head;
    logic at_tail;
    int i;
    case (func)
      OP_ADD_HEAD, OP_ADD_TAIL: begin
        if (!lvl_map[p]) begin
          head_of[p] = t;
          tail_of[p] = t;
          lvl_map[p] = 1'b1;
          if (!top_ok || top_lvl < p) begin
            top_lvl = p;
            top_ok = 1'b1;
          end
        end else if (func == OP_ADD_TAIL) begin
          old = tail_of[p];
          next_of[old] = t;
          next_set[old] = 1'b1;
          prev_of[t] = old;
          prev_set[t] = 1'b1;
          tail_of[p] = t;
        end else begin
          old = head_of[p];
          prev_of[old] = t;
          prev_set[old] = 1'b1;
          next_of[t] = old;
          next_set[t] = 1'b1;
          head_of[p] = t;
        end
      end
      OP_REMOVE: begin
        if (lvl_map[p]) begin
          at_head = (head_of[p] == t);
          at_tail = (tail_of[p] == t);
          if (at_head && at_tail) begin
            lvl_map[p] = 1'b0;
            top_ok = 1'b0;
            top_lvl = '0;
            for (i = 0; i < NUM_PRIO; i++) begin
              if (lvl_map[i]) begin
                top_ok = 1'b1;
                top_lvl = lvl_t'(i);
              end
            end
          end else if (at_head) begin
            head_of[p] = next_of[t];
          end else if (at_tail) begin
            tail_of[p] = prev_of[t];
          end else begin
            bef = prev_of[t];
            aft = next_of[t];
            next_of[bef] = aft;
            next_set[bef] = 1'b1;
            prev_of[aft] = bef;
            prev_set[aft] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    v.rdy = top_ok;
    v.top = top_ok ? top_lvl : '0;
    v.thr = top_ok ? head_of[top_lvl] : '0;
    return v;
  endfunction

  // A removal may follow links of a thread that were never stored; such a request is avoided.
  function automatic bit reads_blank_link(logic [FUNC_W-1:0] func, tid_t t, lvl_t p);
    logic at_head;
    logic at_tail;
    if (func != OP_REMOVE || !lvl_map[p]) return 1'b0;
    at_head = (head_of[p] == t);
    at_tail = (tail_of[p] == t);
    if (at_head && at_tail) return 1'b0;
    if (at_head) return !next_set[t];
    if (at_tail) return !prev_set[t];
    return !(next_set[t] && prev_set[t]);
  endfunction

  task automatic pick_request(input bit broken, output logic [FUNC_W-1:0] f, output tid_t t,
                              output lvl_t p);
    int r;
    int k;
    int pool [$];
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 39) == 0) begin
      filling = !filling;
      for (k = 0; k < 3; k++) hot_lvl[k] = lvl_t'($urandom_range(0, NUM_PRIO - 1));
    end
    for (k = 0; k < NUM_THREADS; k++) begin
      if (lvl_of[k] >= 0) pool.push_back(k);
    end
    t = tid_t'($urandom_range(0, NUM_THREADS - 1));
    p = lvl_t'($urandom_range(0, NUM_PRIO - 1));
    f = FUNC_UNUSED;
    if (broken && r < 30 && pool.size() != 0) begin
      t = tid_t'(pool[$urandom_range(0, pool.size() - 1)]);
      if ($urandom_range(0, 1) == 1) p = lvl_t'(lvl_of[t]);
      f = ($urandom_range(0, 1) == 1) ? OP_ADD_TAIL : OP_ADD_HEAD;
    end else if (broken && r < 60) begin
      f = OP_REMOVE;
    end else if (r < 6) begin
      f = FUNC_UNUSED;
    end else if (r < 10 && !lvl_map[p]) begin
      f = OP_REMOVE;
    end else if (pool.size() == NUM_THREADS ||
                 (pool.size() != 0 && $urandom_range(0, 99) < (filling ? 30 : 75))) begin
      t = tid_t'(pool[$urandom_range(0, pool.size() - 1)]);
      p = lvl_t'(lvl_of[t]);
      f = OP_REMOVE;
    end else begin
      while (lvl_of[t] >= 0) t = tid_t'($urandom_range(0, NUM_THREADS - 1));
      if ($urandom_range(0, 1) == 1) p = hot_lvl[$urandom_range(0, 2)];
      f = ($urandom_range(0, 1) == 1) ? OP_ADD_TAIL : OP_ADD_HEAD;
    end
    if (reads_blank_link(f, t, p)) f = FUNC_UNUSED;
  endtask

  task automatic send_request(input logic [FUNC_W-1:0] f, input tid_t t, input lvl_t p,
                              input logic typed, input ready_view_t typed_view);
    int gap;
    ready_view_t v;
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_thread_id <= t;
    in_prio <= p;
    do @(posedge clk); while (!in_ready);
    v = apply_request(f, t, p);
    pending_views.push_back(typed ? typed_view : v);
    if (f == OP_ADD_HEAD || f == OP_ADD_TAIL) begin
      lvl_of[t] = int'(p);
    end else if (f == OP_REMOVE && lvl_of[t] == int'(p)) begin
      lvl_of[t] = -1;
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_views.size() != 0);
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", what);
  endtask

  initial begin : drive_requests
    int i;
    int n;
    logic [FUNC_W-1:0] f;
    tid_t t;
    lvl_t p;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= '0;
    in_thread_id <= '0;
    in_prio <= '0;
    lvl_map = '0;
    top_ok = 1'b0;
    top_lvl = '0;
    foreach (head_of[k]) begin
      head_of[k] = '0;
      tail_of[k] = '0;
    end
    foreach (next_of[k]) begin
      next_of[k] = '0;
      prev_of[k] = '0;
      next_set[k] = 1'b0;
      prev_set[k] = 1'b0;
      lvl_of[k] = -1;
    end
    filling = 1'b1;
    for (i = 0; i < 3; i++) hot_lvl[i] = lvl_t'($urandom_range(0, NUM_PRIO - 1));
    tx_steady = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = 0; i < $size(DIRECTED_ROWS); i++) begin
      send_request(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].tid, DIRECTED_ROWS[i].prio,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].view);
    end
    hold_until_drained();
    for (n = 0; n < WELL_FORMED_ITEMS + BROKEN_ITEMS; n++) begin
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) hold_until_drained();
      pick_request(n >= WELL_FORMED_ITEMS, f, t, p);
      send_request(f, t, p, 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_views.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : drain_results
    int w;
    out_ready <= 1'b0;
    rx_steady = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      w = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (w != 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  always @(posedge clk) begin : check_results
    ready_view_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_views.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: ready_valid %0d top_prio %0d chosen_thread %0d",
                                out_ready_valid, out_top_prio, out_chosen_thread));
      end else begin
        want = pending_views.pop_front();
        if (out_ready_valid !== want.rdy)
          flag_mismatch($sformatf("ready_valid: expected %0d, got %0d", want.rdy, out_ready_valid));
        if (out_top_prio !== want.top)
          flag_mismatch($sformatf("top_prio: expected %0d, got %0d", want.top, out_top_prio));
        if (out_chosen_thread !== want.thr)
          flag_mismatch($sformatf("chosen_thread: expected %0d, got %0d", want.thr,
                                  out_chosen_thread));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/prq_pkg.sv
rtl/core/prq_ram.sv
rtl/core/prq_fls.sv
rtl/core/prq_list_table.sv
rtl/core/priority_ready_queue_unit.sv
rtl/core/prq_checker.sv
tb/tb.sv
